@@ design/bqmj_pkg.sv @@
// Shared types, register codes and saturation helper for the bilinear quad map unit.
package bqmj_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NodeW   = 32;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ShapeW  = 18;   // 1 +/- coordinate, Q4.14 with headroom
  localparam int unsigned WeightW = 34;   // product of two shape factors
  localparam int unsigned GprodW  = 64;
  localparam int unsigned GsumW   = 66;
  localparam int unsigned JprodW  = 51;
  localparam int unsigned JsumW   = 52;
  localparam int unsigned PreSatW = 36;

  localparam logic signed [ShapeW-1:0]  OneQ14 = 18'sd16384;
  localparam logic signed [PreSatW-1:0] SatHi  = 36'sd2147483647;
  localparam logic signed [PreSatW-1:0] SatLo  = -36'sd2147483648;
  localparam logic [NodeW-1:0]          MaxQ16 = 32'h7FFF_FFFF;
  localparam logic [NodeW-1:0]          MinQ16 = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_NODE1_X = 3'd0,
    REG_NODE1_Y = 3'd1,
    REG_NODE2_X = 3'd2,
    REG_NODE2_Y = 3'd3,
    REG_NODE3_X = 3'd4,
    REG_NODE3_Y = 3'd5,
    REG_NODE4_X = 3'd6,
    REG_NODE4_Y = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ref_xi;
    logic signed [CoordW-1:0] ref_eta;
  } in_t;

  typedef struct packed {
    logic signed [NodeW-1:0] global_x;
    logic signed [NodeW-1:0] global_y;
    logic signed [NodeW-1:0] jac_x_xi;
    logic signed [NodeW-1:0] jac_x_eta;
    logic signed [NodeW-1:0] jac_y_xi;
    logic signed [NodeW-1:0] jac_y_eta;
  } out_t;

  typedef logic [3:0][NodeW-1:0]   node_vec_t;
  typedef logic [3:0][WeightW-1:0] weight_vec_t;

  // Load enables for the stages that live inside each coordinate lane.
  typedef struct packed {
    logic prod;
    logic sum;
    logic sat;
  } lane_en_t;

  function automatic logic [NodeW-1:0] sat_q16(logic signed [PreSatW-1:0] v);
    logic [NodeW-1:0] r;
    if (v > SatHi) begin
      r = MaxQ16;
    end else if (v < SatLo) begin
      r = MinQ16;
    end else begin
      r = v[NodeW-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/bilinear_quad_map_and_jacobian_unit.sv @@
// Top level of the bilinear quadrilateral map and Jacobian unit.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o    in_i (ref_xi, ref_eta)
//   out      out        out_valid_o/out_ready_i  out_o (point and Jacobian)
//
// Five register stages: shape factors, shape weights, node products, sums,
// floor shift with saturation. One point enters every cycle while the output
// is not stalled; the 32x34 node multipliers set the stage depth.
// Reset clears the stage valid bits and sets all node registers to zero.
// A stall at the output backs up stage by stage; in_ready_o falls only once
// every stage holds a beat. Node writes are always accepted.
module bilinear_quad_map_and_jacobian_unit
  import bqmj_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [NodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_o
);

  localparam int unsigned NumStages = 5;

  logic [7:0][NodeW-1:0]     node_q;
  logic [NumStages-1:0]      vld_q;
  logic [NumStages-1:0]      en;
  logic signed [ShapeW-1:0]  u, v;
  logic signed [ShapeW-1:0]  um_q, up_q, vm_q, vp_q;
  logic signed [ShapeW-1:0]  um2_q, up2_q, vm2_q, vp2_q;
  logic signed [2*ShapeW-1:0] w0_full, w1_full, w2_full, w3_full;
  weight_vec_t               w_q;
  node_vec_t                 nodes_x, nodes_y;
  lane_en_t                  lane_en;
  logic [NodeW-1:0]          gx, gy, jxx, jxe, jyx, jye;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '0;
    end else if (cfg_valid_i && cfg_index_i[CfgIdxW-1] == 1'b0) begin
      node_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // A stage loads when it is empty or its content moves on in the same cycle.
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  assign u = ShapeW'(in_i.ref_xi);
  assign v = ShapeW'(in_i.ref_eta);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      um_q <= OneQ14 - u;
      up_q <= OneQ14 + u;
      vm_q <= OneQ14 - v;
      vp_q <= OneQ14 + v;
    end
  end

  assign w0_full = um_q * vm_q;
  assign w1_full = up_q * vm_q;
  assign w2_full = up_q * vp_q;
  assign w3_full = um_q * vp_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      w_q[0] <= w0_full[WeightW-1:0];
      w_q[1] <= w1_full[WeightW-1:0];
      w_q[2] <= w2_full[WeightW-1:0];
      w_q[3] <= w3_full[WeightW-1:0];
      um2_q  <= um_q;
      up2_q  <= up_q;
      vm2_q  <= vm_q;
      vp2_q  <= vp_q;
    end
  end

  assign nodes_x[0] = node_q[REG_NODE1_X];
  assign nodes_x[1] = node_q[REG_NODE2_X];
  assign nodes_x[2] = node_q[REG_NODE3_X];
  assign nodes_x[3] = node_q[REG_NODE4_X];
  assign nodes_y[0] = node_q[REG_NODE1_Y];
  assign nodes_y[1] = node_q[REG_NODE2_Y];
  assign nodes_y[2] = node_q[REG_NODE3_Y];
  assign nodes_y[3] = node_q[REG_NODE4_Y];

  assign lane_en.prod = en[2];
  assign lane_en.sum  = en[3];
  assign lane_en.sat  = en[4];

  bqmj_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .node_i  (nodes_x),
    .w_i     (w_q),
    .um_i    (um2_q),
    .up_i    (up2_q),
    .vm_i    (vm2_q),
    .vp_i    (vp2_q),
    .glob_o  (gx),
    .d_xi_o  (jxx),
    .d_eta_o (jxe)
  );

  bqmj_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .node_i  (nodes_y),
    .w_i     (w_q),
    .um_i    (um2_q),
    .up_i    (up2_q),
    .vm_i    (vm2_q),
    .vp_i    (vp2_q),
    .glob_o  (gy),
    .d_xi_o  (jyx),
    .d_eta_o (jye)
  );

  assign out_o.global_x  = gx;
  assign out_o.global_y  = gy;
  assign out_o.jac_x_xi  = jxx;
  assign out_o.jac_x_eta = jxe;
  assign out_o.jac_y_xi  = jyx;
  assign out_o.jac_y_eta = jye;

  // Input back-pressure only appears with a full pipe and a stalled output.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q) && !out_ready_i)
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat did not enter the first stage");

  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i[CfgIdxW-1] |=> $stable(node_q))
    else $error("write beyond the node registers changed a node");

endmodule

@@ design/bqmj_lane.sv @@
// One coordinate lane: node products, sums, floor shift and saturation.
module bqmj_lane
  import bqmj_pkg::*;
(
  input  logic                     clk_i,
  input  lane_en_t                 en_i,
  input  node_vec_t                node_i,
  input  weight_vec_t              w_i,
  input  logic signed [ShapeW-1:0] um_i,
  input  logic signed [ShapeW-1:0] up_i,
  input  logic signed [ShapeW-1:0] vm_i,
  input  logic signed [ShapeW-1:0] vp_i,
  output logic [NodeW-1:0]         glob_o,
  output logic [NodeW-1:0]         d_xi_o,
  output logic [NodeW-1:0]         d_eta_o
);

  logic signed [GsumW-1:0]  gprod_full [4];
  logic signed [GprodW-1:0] gprod_q [4];
  logic signed [NodeW:0]    d10, d23, d30, d21;
  logic signed [JprodW-1:0] pa_d, pb_d, pc_d, pd_d;
  logic signed [JprodW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [GsumW-1:0]  gsum_d, gsum_q;
  logic signed [JsumW-1:0]  jxi_d, jxi_q, jeta_d, jeta_q;
  logic [NodeW-1:0]         glob_q, d_xi_q, d_eta_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      gprod_full[k] = $signed(node_i[k]) * $signed(w_i[k]);
    end
  end

  // Jacobian terms factor into node differences times one shape factor.
  assign d10  = $signed({node_i[1][NodeW-1], node_i[1]}) - $signed({node_i[0][NodeW-1], node_i[0]});
  assign d23  = $signed({node_i[2][NodeW-1], node_i[2]}) - $signed({node_i[3][NodeW-1], node_i[3]});
  assign d30  = $signed({node_i[3][NodeW-1], node_i[3]}) - $signed({node_i[0][NodeW-1], node_i[0]});
  assign d21  = $signed({node_i[2][NodeW-1], node_i[2]}) - $signed({node_i[1][NodeW-1], node_i[1]});
  assign pa_d = d10 * vm_i;
  assign pb_d = d23 * vp_i;
  assign pc_d = d30 * um_i;
  assign pd_d = d21 * up_i;

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      for (int k = 0; k < 4; k++) begin
        gprod_q[k] <= gprod_full[k][GprodW-1:0];
      end
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
      pd_q <= pd_d;
    end
  end

  assign gsum_d = gprod_q[0] + gprod_q[1] + gprod_q[2] + gprod_q[3];
  assign jxi_d  = pa_q + pb_q;
  assign jeta_d = pc_q + pd_q;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      gsum_q <= gsum_d;
      jxi_q  <= jxi_d;
      jeta_q <= jeta_d;
    end
  end

  // Dropping low bits of a two's complement value is a floor division.
  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      glob_q  <= sat_q16(gsum_q[GsumW-1:30]);
      d_xi_q  <= sat_q16(jxi_q[JsumW-1:16]);
      d_eta_q <= sat_q16(jeta_q[JsumW-1:16]);
    end
  end

  assign glob_o  = glob_q;
  assign d_xi_o  = d_xi_q;
  assign d_eta_o = d_eta_q;

endmodule

@@ sim/bilinear_quad_map_and_jacobian_unit_test.sv @@
// Self-checking testbench for the bilinear quadrilateral map and Jacobian unit.
`timescale 1ns / 100ps

module bilinear_quad_map_and_jacobian_unit_test;
  import bqmj_pkg::*;

  typedef logic signed [71:0] wide_t;

  typedef enum int {
    NODES_SMALL,
    NODES_FULL,
    NODES_EDGE,
    NODES_MIXED
  } node_mix_e;

  localparam int NumNodeRegs = int'(REG_NODE4_Y) + 1;
  localparam int Q16One      = 65536;
  localparam int SmallSpan   = 1 << 25;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 8;
  localparam int QuietLimit  = 5000;
  localparam logic [CoordW-1:0] CoordMin = 16'h8000;
  localparam logic [CoordW-1:0] CoordMax = 16'h7FFF;
  localparam logic [CoordW-1:0] PlusOne  = CoordW'(OneQ14);
  localparam logic [CoordW-1:0] MinusOne = CoordW'(-OneQ14);

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [NodeW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;

  // Node coordinates as the block should hold them.
  logic signed [NodeW-1:0] node_q [NumNodeRegs];
  logic [NodeW-1:0]        next_nodes [NumNodeRegs];
  out_t                    pending_maps [$];

  logic src_idle_on  = 1'b1;
  logic sink_idle_on = 1'b1;
  logic hold_req     = 1'b0;
  int   points_sent;
  int   maps_checked;
  int   elements_loaded;
  int   mismatches;
  int   quiet_cycles;

  bilinear_quad_map_and_jacobian_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [NodeW-1:0] clamp_q16(wide_t v);
    logic [NodeW-1:0] r;
    if (v > SatHi) begin
      r = MaxQ16;
    end else if (v < SatLo) begin
      r = MinQ16;
    end else begin
      r = v[NodeW-1:0];
    end
    return r;
  endfunction

  // Shape weights are Q28; the shift by 30 folds in the quarter factor.
  function automatic out_t map_point(in_t pt);
    wide_t            xi, eta, xm, xp, em, ep, gsum, dxi, deta;
    wide_t            wt [4];
    wide_t            nd [4];
    logic [NodeW-1:0] res [6];
    out_t             r;
    int               c, k;
    xi    = pt.ref_xi;
    eta   = pt.ref_eta;
    xm    = OneQ14 - xi;
    xp    = OneQ14 + xi;
    em    = OneQ14 - eta;
    ep    = OneQ14 + eta;
    wt[0] = xm * em;
    wt[1] = xp * em;
    wt[2] = xp * ep;
    wt[3] = xm * ep;
    for (c = 0; c < 2; c++) begin
      for (k = 0; k < 4; k++) begin
        nd[k] = node_q[2 * k + c];
      end
      gsum = nd[0] * wt[0] + nd[1] * wt[1] + nd[2] * wt[2] + nd[3] * wt[3];
      dxi  = -nd[0] * em + nd[1] * em + nd[2] * ep - nd[3] * ep;
      deta = -nd[0] * xm - nd[1] * xp + nd[2] * xp + nd[3] * xm;
      res[c]         = clamp_q16(gsum >>> 30);
      res[2 + 2 * c] = clamp_q16(dxi >>> 16);
      res[3 + 2 * c] = clamp_q16(deta >>> 16);
    end
    r.global_x  = res[0];
    r.global_y  = res[1];
    r.jac_x_xi  = res[2];
    r.jac_x_eta = res[3];
    r.jac_y_xi  = res[4];
    r.jac_y_eta = res[5];
    return r;
  endfunction

  function automatic in_t pt(logic [CoordW-1:0] xi, logic [CoordW-1:0] eta);
    in_t p;
    p.ref_xi  = xi;
    p.ref_eta = eta;
    return p;
  endfunction

  // Mostly points inside the element, some on its corners and edges, the rest anywhere.
  function automatic in_t random_point();
    in_t p;
    int  sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      p.ref_xi  = $urandom_range(2 * OneQ14) - OneQ14;
      p.ref_eta = $urandom_range(2 * OneQ14) - OneQ14;
    end else if (sel < 85) begin
      p.ref_xi  = (int'($urandom_range(2)) - 1) * OneQ14;
      p.ref_eta = (int'($urandom_range(2)) - 1) * OneQ14;
    end else begin
      p = $urandom;
    end
    return p;
  endfunction

  function automatic logic [NodeW-1:0] random_node(node_mix_e mix);
    node_mix_e        m;
    logic [NodeW-1:0] r;
    int               sel;
    m = mix;
    if (m == NODES_MIXED) begin
      m = node_mix_e'($urandom_range(int'(NODES_EDGE)));
    end
    sel = $urandom_range(3);
    case (m)
      NODES_SMALL: begin
        r = $urandom_range(SmallSpan) - SmallSpan / 2;
      end
      NODES_EDGE: begin
        if (sel == 0) begin
          r = MaxQ16;
        end else if (sel == 1) begin
          r = MinQ16;
        end else if (sel == 2) begin
          r = '0;
        end else begin
          r = '1;
        end
      end
      default: begin
        r = $urandom;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [NodeW-1:0] want,
                             input logic [NodeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_point(input in_t p);
    while (src_idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_maps.push_back(map_point(p));
    points_sent++;
  endtask

  // Stop offering points and let every outstanding result come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_node(input logic [CfgIdxW-1:0] idx, input logic [NodeW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NumNodeRegs) begin
      node_q[idx] = data;
    end
  endtask

  task automatic load_element();
    int k;
    wait_drained();
    for (k = 0; k < NumNodeRegs; k++) begin
      write_node(CfgIdxW'(k), next_nodes[k]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    elements_loaded++;
  endtask

  task automatic make_element(input node_mix_e mix);
    int k;
    for (k = 0; k < NumNodeRegs; k++) begin
      next_nodes[k] = random_node(mix);
    end
  endtask

  task automatic test_reset_state();
    send_point(pt(PlusOne, MinusOne));
    send_point(random_point());
  endtask

  task automatic test_corner_points();
    next_nodes[REG_NODE1_X] = '0;
    next_nodes[REG_NODE1_Y] = '0;
    next_nodes[REG_NODE2_X] = 2 * Q16One;
    next_nodes[REG_NODE2_Y] = '0;
    next_nodes[REG_NODE3_X] = 3 * Q16One;
    next_nodes[REG_NODE3_Y] = 2 * Q16One;
    next_nodes[REG_NODE4_X] = '0;
    next_nodes[REG_NODE4_Y] = Q16One;
    load_element();
    send_point(pt(MinusOne, MinusOne));
    send_point(pt(PlusOne, MinusOne));
    send_point(pt(PlusOne, PlusOne));
    send_point(pt(MinusOne, PlusOne));
    send_point(pt('0, '0));
    send_point(pt('0, MinusOne));
    send_point(pt(PlusOne, '0));
    send_point(pt(CoordMin, CoordMin));
    send_point(pt(CoordMax, CoordMax));
    send_point(pt(CoordMin, CoordMax));
  endtask

  task automatic test_saturation();
    int k;
    // Equal nodes at the limits: the mapped point stays at the limit even when extrapolated.
    for (k = 0; k < NumNodeRegs; k += 2) begin
      next_nodes[k]     = MaxQ16;
      next_nodes[k + 1] = MinQ16;
    end
    load_element();
    send_point(pt(CoordMin, CoordMin));
    send_point(pt(CoordMax, CoordMax));
    send_point(pt('0, '0));
    send_point(pt(PlusOne, MinusOne));
    // Alternating limits drive the Jacobian past both ends.
    next_nodes[REG_NODE1_X] = MaxQ16;
    next_nodes[REG_NODE1_Y] = MinQ16;
    next_nodes[REG_NODE2_X] = MinQ16;
    next_nodes[REG_NODE2_Y] = MaxQ16;
    next_nodes[REG_NODE3_X] = MaxQ16;
    next_nodes[REG_NODE3_Y] = MinQ16;
    next_nodes[REG_NODE4_X] = MinQ16;
    next_nodes[REG_NODE4_Y] = MaxQ16;
    load_element();
    send_point(pt(CoordMin, CoordMax));
    send_point(pt(CoordMax, CoordMin));
    send_point(pt(MinusOne, MinusOne));
    send_point(pt('0, PlusOne));
  endtask

  task automatic test_ignored_index();
    make_element(NODES_SMALL);
    load_element();
    write_node(CfgIdxW'(NumNodeRegs), $urandom);
    write_node('1, $urandom);
    write_node(CfgIdxW'($urandom_range(NumNodeRegs, (1 << CfgIdxW) - 1)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_point(pt(MinusOne, MinusOne));
    send_point(pt(PlusOne, PlusOne));
    send_point(random_point());
  endtask

  task automatic test_random_elements();
    int ph, i;
    for (ph = 0; ph < 6; ph++) begin
      make_element(node_mix_e'(ph % 4));
      load_element();
      // One phase runs with both sides at full rate.
      src_idle_on  = (ph != 4);
      sink_idle_on = (ph != 4);
      for (i = 0; i < 300; i++) begin
        if (ph == 1 && i == 150) begin
          wait_drained();
        end
        send_point(random_point());
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // The receiver stalls long enough for the pipeline to fill and block the input.
  task automatic test_backpressure();
    int i;
    make_element(NODES_MIXED);
    load_element();
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    for (i = 0; i < 60; i++) begin
      send_point(random_point());
    end
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= !(sink_idle_on && $urandom_range(99) < 14);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_data);
        mismatches++;
      end else begin
        want = pending_maps.pop_front();
        check_field("global_x", want.global_x, out_data.global_x);
        check_field("global_y", want.global_y, out_data.global_y);
        check_field("jac_x_xi", want.jac_x_xi, out_data.jac_x_xi);
        check_field("jac_x_eta", want.jac_x_eta, out_data.jac_x_eta);
        check_field("jac_y_xi", want.jac_y_xi, out_data.jac_y_xi);
        check_field("jac_y_eta", want.jac_y_eta, out_data.jac_y_eta);
      end
      maps_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < NumNodeRegs; k++) begin
      node_q[k] = '0;
    end
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_corner_points();
    test_saturation();
    test_ignored_index();
    test_random_elements();
    test_backpressure();
    wait_drained();

    $display("Mapped %0d points and checked %0d results over %0d node sets.",
             points_sent, maps_checked, elements_loaded);
    $display("Included saturation, extrapolation, ignored writes and output stalls.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
